// ===== rtl/msgp_pkg.sv =====
// msgp_pkg: shared types, codes and constants of the multi-stop gradient core
// depends on nothing; imported by every module of the block

package msgp_pkg;

  localparam int COORD_W = 14;
  localparam int PIX_W   = 12;
  localparam int DIFF_W  = 15;
  localparam int POS_W   = 16;
  localparam int COLOR_W = 32;
  localparam int FN_W    = 16;
  localparam int ANG_W   = 22;

  localparam logic [1:0] KIND_LINEAR  = 2'd0;
  localparam logic [1:0] KIND_RADIAL  = 2'd1;
  localparam logic [1:0] KIND_ANGULAR = 2'd2;

  localparam logic [1:0] REGION_FIRST  = 2'd0;
  localparam logic [1:0] REGION_INTERP = 2'd1;
  localparam logic [1:0] REGION_LAST   = 2'd2;

  localparam logic [2:0] REG_KIND       = 3'd0;
  localparam logic [2:0] REG_START_X    = 3'd1;
  localparam logic [2:0] REG_START_Y    = 3'd2;
  localparam logic [2:0] REG_END_X      = 3'd3;
  localparam logic [2:0] REG_END_Y      = 3'd4;
  localparam logic [2:0] REG_STOP_COUNT = 3'd5;

  // half a turn in 2^-20 turn units
  localparam logic signed [ANG_W-1:0] ANG_HALF = 22'sd524288;

  typedef struct packed {
    logic            early;
    logic            last;
    logic [FN_W-1:0] fn;
  } frac_res_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [POS_W-1:0]   pos;
  } stop_entry_t;

  // atan(2^-i) in 2^-20 turns
  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [3:0] i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      4'd0:  v = 22'sd131072;
      4'd1:  v = 22'sd77376;
      4'd2:  v = 22'sd40884;
      4'd3:  v = 22'sd20753;
      4'd4:  v = 22'sd10417;
      4'd5:  v = 22'sd5213;
      4'd6:  v = 22'sd2607;
      4'd7:  v = 22'sd1304;
      4'd8:  v = 22'sd652;
      4'd9:  v = 22'sd326;
      4'd10: v = 22'sd163;
      4'd11: v = 22'sd81;
      4'd12: v = 22'sd41;
      4'd13: v = 22'sd20;
      4'd14: v = 22'sd10;
      default: v = 22'sd5;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/multi_stop_gradient_pixel_core.sv =====
// multi_stop_gradient_pixel_core: one pixel item in, at most one color item out
// path: fraction unit, then stop walk, then hand-off to the output register
// flow: one item at a time; stop write items are taken while idle and give no result
// reset: rst synchronous active high; registers take their reset values, the
//   stop store has no reset and no clearing pass

module multi_stop_gradient_pixel_core import msgp_pkg::*; #(
  parameter int MAX_STOPS  = 16,
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_x[11:0], pixel_y[23:12], stop_index[27:24], stop_position[43:28],
  // stop_color[75:44], zero fill [79:76]
  input  logic [79:0] s_axis_tdata,
  // mode[0]
  input  logic        s_axis_tuser,
  // result item stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_color[31:0]
  output logic [31:0] m_axis_tdata,
  // region[1:0]
  output logic [1:0]  m_axis_tuser,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_STOPS);
  localparam int NW = $clog2(MAX_STOPS + 1);

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_FRAC  = 2'd1;
  localparam logic [1:0] T_SHADE = 2'd2;
  localparam logic [1:0] T_HOLD  = 2'd3;

  // input fields
  logic [PIX_W-1:0]   pixel_x, pixel_y;
  logic [3:0]         stop_index;
  logic [POS_W-1:0]   stop_position;
  logic [COLOR_W-1:0] stop_color;
  assign pixel_x       = s_axis_tdata[11:0];
  assign pixel_y       = s_axis_tdata[23:12];
  assign stop_index    = s_axis_tdata[27:24];
  assign stop_position = s_axis_tdata[43:28];
  assign stop_color    = s_axis_tdata[75:44];

  // configuration registers
  logic [1:0]                gradient_kind;
  logic signed [COORD_W-1:0] start_x, start_y, end_x, end_y;
  logic [4:0]                stop_count;
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gradient_kind <= KIND_LINEAR;
      start_x       <= '0;
      start_y       <= '0;
      end_x         <= '0;
      end_y         <= '0;
      stop_count    <= 5'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KIND:       gradient_kind <= pwdata[1:0];
        REG_START_X:    start_x       <= pwdata[COORD_W-1:0];
        REG_START_Y:    start_y       <= pwdata[COORD_W-1:0];
        REG_END_X:      end_x         <= pwdata[COORD_W-1:0];
        REG_END_Y:      end_y         <= pwdata[COORD_W-1:0];
        REG_STOP_COUNT: stop_count    <= pwdata[4:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KIND:       prdata = {30'b0, gradient_kind};
      REG_START_X:    prdata = {18'b0, start_x};
      REG_START_Y:    prdata = {18'b0, start_y};
      REG_END_X:      prdata = {18'b0, end_x};
      REG_END_Y:      prdata = {18'b0, end_y};
      REG_STOP_COUNT: prdata = {27'b0, stop_count};
      default:        prdata = '0;
    endcase
  end

  // effective stop count: zero reads as one, large counts saturate
  int n_int;
  logic [NW-1:0] n;
  always_comb begin
    if (stop_count == 5'd0) begin
      n_int = 1;
    end else if (int'(stop_count) > MAX_STOPS) begin
      n_int = MAX_STOPS;
    end else begin
      n_int = int'(stop_count);
    end
  end
  assign n = NW'(n_int);

  // sequencer
  logic [1:0] state;
  logic       in_acc, in_frame, frac_go, stop_wr;
  assign s_axis_tready = state == T_IDLE;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_frame      = int'(pixel_x) < MAX_WIDTH && int'(pixel_y) < MAX_HEIGHT;
  // out-of-frame pixels are dropped without a result
  assign frac_go       = in_acc && !s_axis_tuser && in_frame;
  assign stop_wr       = in_acc && s_axis_tuser && int'(stop_index) < MAX_STOPS;

  logic      frac_done, shade_done;
  frac_res_t frac_res;
  logic [COLOR_W-1:0] shade_color;
  logic [1:0]         shade_region;
  logic               out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      unique case (state)
        T_IDLE:  if (frac_go) state <= T_FRAC;
        T_FRAC:  if (frac_done) state <= T_SHADE;
        T_SHADE: if (shade_done) state <= T_HOLD;
        default: if (out_free) state <= T_IDLE;
      endcase
    end
  end

  // output register parts the result side from the core
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == T_HOLD && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_HOLD && out_free) begin
      m_axis_tdata <= shade_color;
      m_axis_tuser <= shade_region;
    end
  end

  // stop store
  stop_entry_t   wr_entry, rd_entry;
  logic [AW-1:0] rd_addr;
  assign wr_entry.color = stop_color;
  assign wr_entry.pos   = stop_position;

  msgp_stop_mem #(
    .DEPTH (MAX_STOPS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (stop_wr),
    .wr_addr (AW'(stop_index)),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  msgp_frac u_frac (
    .clk     (clk),
    .rst     (rst),
    .go      (frac_go),
    .kind    (gradient_kind),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .done    (frac_done),
    .res     (frac_res)
  );

  msgp_shade #(
    .AW (AW),
    .NW (NW)
  ) u_shade (
    .clk     (clk),
    .rst     (rst),
    .go      (frac_done),
    .res_in  (frac_res),
    .n       (n),
    .rd_addr (rd_addr),
    .rd_data (rd_entry),
    .done    (shade_done),
    .color   (shade_color),
    .region  (shade_region)
  );

endmodule

// ===== rtl/msgp_stop_mem.sv =====
// msgp_stop_mem: stop store, one write port and one registered read port
// depends on msgp_pkg for the entry type

module msgp_stop_mem import msgp_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [AW-1:0] wr_addr,
  input  stop_entry_t wr_data,
  input  logic [AW-1:0] rd_addr,
  output stop_entry_t rd_data
);

  stop_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/msgp_frac.sv =====
// msgp_frac: gradient fraction unit, shared multiplier, restoring divider,
// digit square root and cordic; depends on msgp_pkg

module msgp_frac import msgp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [1:0]                kind,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic [PIX_W-1:0]          pixel_x,
  input  logic [PIX_W-1:0]          pixel_y,
  output logic                      done,
  output frac_res_t                 res
);

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_MUL    = 3'd1;
  localparam logic [2:0] F_DECIDE = 3'd2;
  localparam logic [2:0] F_DIV    = 3'd3;
  localparam logic [2:0] F_SQRT   = 3'd4;
  localparam logic [2:0] F_CINIT  = 3'd5;
  localparam logic [2:0] F_CSTEP  = 3'd6;
  localparam logic [2:0] F_DONE   = 3'd7;

  logic [2:0] state;
  logic signed [DIFF_W-1:0] dx, dy, qx, qy;
  logic [2:0] mcnt;
  logic signed [31:0] d2, pp, q2;
  logic radial;

  logic [31:0] rem, den, quo;
  logic [5:0]  dcnt;

  logic [31:0] sv;
  logic [15:0] sroot;
  logic [17:0] srem;
  logic [4:0]  scnt;

  logic signed [33:0] cx, cy;
  logic signed [ANG_W-1:0] ca;
  logic [3:0] ci;
  logic cpass;
  logic [FN_W-1:0] r_ref;

  // multiplier operand select
  logic signed [DIFF_W-1:0] ma, mb;
  logic signed [2*DIFF_W-1:0] prod;
  logic signed [31:0] prod_ext;

  always_comb begin
    unique case (mcnt)
      3'd0: begin ma = dx; mb = dx; end
      3'd1: begin ma = dy; mb = dy; end
      3'd2: begin ma = dx; mb = qx; end
      3'd3: begin ma = dy; mb = qy; end
      3'd4: begin ma = qx; mb = qx; end
      default: begin ma = qy; mb = qy; end
    endcase
  end

  assign prod     = ma * mb;
  assign prod_ext = $signed({{(32-2*DIFF_W){prod[2*DIFF_W-1]}}, prod});

  // divider step
  logic [31:0] rem_sh, rem_next, quo_next;
  logic        div_ge;
  assign rem_sh   = {rem[30:0], 1'b0};
  assign div_ge   = rem_sh >= den;
  assign rem_next = div_ge ? rem_sh - den : rem_sh;
  assign quo_next = {quo[30:0], div_ge};

  // square root step
  logic [19:0] s_sh, s_trial, s_diff;
  logic        s_ge;
  logic [17:0] srem_next;
  logic [15:0] root_next;
  assign s_sh      = {srem, sv[31:30]};
  assign s_trial   = {2'b00, sroot, 2'b01};
  assign s_ge      = s_sh >= s_trial;
  assign s_diff    = s_sh - s_trial;
  assign srem_next = s_ge ? s_diff[17:0] : s_sh[17:0];
  assign root_next = {sroot[14:0], s_ge};

  // cordic vector select and step
  logic signed [DIFF_W-1:0] vx, vy, vxa, vya;
  logic vneg;
  logic signed [33:0] xs, ys, cx_n, cy_n;
  logic signed [ANG_W-1:0] ca_n, ca_r;
  logic [FN_W-1:0] ang_n;

  assign vx   = cpass ? qx : dx;
  assign vy   = cpass ? qy : dy;
  assign vneg = vx < 0;
  assign vxa  = vneg ? -vx : vx;
  assign vya  = vneg ? -vy : vy;

  assign xs = cx >>> ci;
  assign ys = cy >>> ci;

  always_comb begin
    if (!cy[33]) begin
      cx_n = cx + ys;
      cy_n = cy - xs;
      ca_n = ca + atan_tab(ci);
    end else begin
      cx_n = cx - ys;
      cy_n = cy + xs;
      ca_n = ca - atan_tab(ci);
    end
  end

  assign ca_r  = ca_n + 22'sd8;
  assign ang_n = ca_r[19:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (go) begin
            dx    <= $signed({end_x[COORD_W-1], end_x}) -
                     $signed({start_x[COORD_W-1], start_x});
            dy    <= $signed({end_y[COORD_W-1], end_y}) -
                     $signed({start_y[COORD_W-1], start_y});
            qx    <= $signed({3'b000, pixel_x}) - $signed({start_x[COORD_W-1], start_x});
            qy    <= $signed({3'b000, pixel_y}) - $signed({start_y[COORD_W-1], start_y});
            d2    <= '0;
            pp    <= '0;
            q2    <= '0;
            mcnt  <= '0;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          unique case (mcnt)
            3'd0, 3'd1: d2 <= d2 + prod_ext;
            3'd2, 3'd3: pp <= pp + prod_ext;
            default:    q2 <= q2 + prod_ext;
          endcase
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd5) begin
            state <= F_DECIDE;
          end
        end
        F_DECIDE: begin
          res.early <= 1'b0;
          res.last  <= 1'b0;
          res.fn    <= '0;
          quo       <= '0;
          den       <= d2;
          priority if (kind == KIND_RADIAL) begin
            if (q2 >= d2) begin
              res.early <= 1'b1;
              res.last  <= 1'b1;
              state     <= F_DONE;
            end else begin
              radial <= 1'b1;
              rem    <= q2;
              dcnt   <= 6'd32;
              state  <= F_DIV;
            end
          end else if (kind == KIND_ANGULAR) begin
            cpass <= 1'b0;
            state <= F_CINIT;
          end else begin
            if (d2 == 0 || pp <= 0) begin
              res.early <= 1'b1;
              state     <= F_DONE;
            end else if (pp >= d2) begin
              res.early <= 1'b1;
              res.last  <= 1'b1;
              state     <= F_DONE;
            end else begin
              radial <= 1'b0;
              rem    <= pp;
              dcnt   <= 6'd16;
              state  <= F_DIV;
            end
          end
        end
        F_DIV: begin
          rem  <= rem_next;
          quo  <= quo_next;
          dcnt <= dcnt - 6'd1;
          if (dcnt == 6'd1) begin
            if (radial) begin
              sv    <= quo_next;
              sroot <= '0;
              srem  <= '0;
              scnt  <= 5'd16;
              state <= F_SQRT;
            end else begin
              res.fn <= quo_next[FN_W-1:0];
              state  <= F_DONE;
            end
          end
        end
        F_SQRT: begin
          sv    <= {sv[29:0], 2'b00};
          srem  <= srem_next;
          sroot <= root_next;
          scnt  <= scnt - 5'd1;
          if (scnt == 5'd1) begin
            res.fn <= root_next;
            state  <= F_DONE;
          end
        end
        F_CINIT: begin
          if (vx == 0 && vy == 0) begin
            // zero vector has angle zero
            if (!cpass) begin
              r_ref <= '0;
              cpass <= 1'b1;
            end else begin
              res.fn <= '0 - r_ref;
              state  <= F_DONE;
            end
          end else begin
            cx    <= $signed({{3{vxa[DIFF_W-1]}}, vxa, 16'h0000});
            cy    <= $signed({{3{vya[DIFF_W-1]}}, vya, 16'h0000});
            ca    <= vneg ? ANG_HALF : '0;
            ci    <= '0;
            state <= F_CSTEP;
          end
        end
        F_CSTEP: begin
          cx <= cx_n;
          cy <= cy_n;
          ca <= ca_n;
          ci <= ci + 4'd1;
          if (ci == 4'd15) begin
            if (!cpass) begin
              r_ref <= ang_n;
              cpass <= 1'b1;
              state <= F_CINIT;
            end else begin
              res.fn <= ang_n - r_ref;
              state  <= F_DONE;
            end
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  assign done = state == F_DONE;

endmodule

// ===== rtl/msgp_shade.sv =====
// msgp_shade: stop table walk, pair renormalize and channel lerp
// depends on msgp_pkg; reads the stop store through a registered port

module msgp_shade import msgp_pkg::*; #(
  parameter int AW = 4,
  parameter int NW = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  frac_res_t          res_in,
  input  logic [NW-1:0]      n,
  output logic [AW-1:0]      rd_addr,
  input  stop_entry_t        rd_data,
  output logic               done,
  output logic [COLOR_W-1:0] color,
  output logic [1:0]         region
);

  localparam logic [3:0] H_IDLE = 4'd0;
  localparam logic [3:0] H_RD0  = 4'd1;
  localparam logic [3:0] H_CHK0 = 4'd2;
  localparam logic [3:0] H_RDN  = 4'd3;
  localparam logic [3:0] H_CHKN = 4'd4;
  localparam logic [3:0] H_RDI  = 4'd5;
  localparam logic [3:0] H_CHKI = 4'd6;
  localparam logic [3:0] H_DIV  = 4'd7;
  localparam logic [3:0] H_T    = 4'd8;
  localparam logic [3:0] H_LERP = 4'd9;
  localparam logic [3:0] H_DONE = 4'd10;

  logic [3:0] state;
  frac_res_t  fr;
  logic [AW-1:0] idx, last_idx;
  logic [POS_W-1:0] prev_pos, span;
  logic [COLOR_W-1:0] prev_col, cur_col, col0;
  logic [17:0] drem;
  logic [16:0] quo;
  logic [4:0]  dcnt;
  logic [7:0]  t;

  assign last_idx = AW'(n - NW'(1));

  always_comb begin
    unique case (state)
      H_RDN:   rd_addr = last_idx;
      H_RDI:   rd_addr = idx;
      default: rd_addr = '0;
    endcase
  end

  // divider step, compare then shift
  logic        d_ge;
  logic [17:0] d_sub;
  logic [16:0] quo_next;
  assign d_ge     = drem >= {2'b00, span};
  assign d_sub    = d_ge ? drem - {2'b00, span} : drem;
  assign quo_next = {quo[15:0], d_ge};

  logic [25:0] tsum;
  assign tsum = ({9'b0, quo} << 8) - {9'b0, quo} + 26'd32768;

  function automatic logic [7:0] lerp_ch(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] tt);
    logic [15:0] s;
    logic [16:0] q;
    s = 16'(a) * 16'(8'd255 - tt) + 16'(b) * 16'(tt) + 16'd127;
    // divide by 255 for values below 65280
    q = {1'b0, s} + 17'(s[15:8]) + 17'd1;
    return q[15:8];
  endfunction

  logic [COLOR_W-1:0] lerp_col;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lerp_col[8*k +: 8] = lerp_ch(prev_col[8*k +: 8], cur_col[8*k +: 8], t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
    end else begin
      unique case (state)
        H_IDLE: begin
          if (go) begin
            fr    <= res_in;
            state <= H_RD0;
          end
        end
        H_RD0: state <= H_CHK0;
        H_CHK0: begin
          col0     <= rd_data.color;
          prev_pos <= rd_data.pos;
          prev_col <= rd_data.color;
          if ((fr.early && !fr.last) || (!fr.early && fr.fn <= rd_data.pos)) begin
            color  <= rd_data.color;
            region <= REGION_FIRST;
            state  <= H_DONE;
          end else begin
            state <= H_RDN;
          end
        end
        H_RDN: state <= H_CHKN;
        H_CHKN: begin
          if (fr.early || fr.fn >= rd_data.pos) begin
            color  <= rd_data.color;
            region <= REGION_LAST;
            state  <= H_DONE;
          end else begin
            idx   <= AW'(1);
            state <= H_RDI;
          end
        end
        H_RDI: state <= H_CHKI;
        H_CHKI: begin
          if (fr.fn >= prev_pos && fr.fn <= rd_data.pos) begin
            cur_col <= rd_data.color;
            span    <= rd_data.pos - prev_pos;
            drem    <= {2'b00, fr.fn - prev_pos};
            quo     <= '0;
            dcnt    <= 5'd17;
            // equal positions give a zero fraction
            state   <= (rd_data.pos == prev_pos) ? H_T : H_DIV;
          end else if (idx == last_idx) begin
            // no enclosing pair in an unsorted table
            color  <= col0;
            region <= REGION_FIRST;
            state  <= H_DONE;
          end else begin
            prev_pos <= rd_data.pos;
            prev_col <= rd_data.color;
            idx      <= idx + AW'(1);
            state    <= H_RDI;
          end
        end
        H_DIV: begin
          drem <= {d_sub[16:0], 1'b0};
          quo  <= quo_next;
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd1) begin
            state <= H_T;
          end
        end
        H_T: begin
          t     <= tsum[23:16];
          state <= H_LERP;
        end
        H_LERP: begin
          color  <= lerp_col;
          region <= REGION_INTERP;
          state  <= H_DONE;
        end
        default: begin
          state <= H_IDLE;
        end
      endcase
    end
  end

  assign done = state == H_DONE;

endmodule

// ===== rtl/msgp_checker.sv =====
// msgp_checker: port-level checks of the gradient core over time
// depends on msgp_pkg and the top level's ports; bound to it below

module msgp_checker import msgp_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [79:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic in_acc, render_acc;
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign render_acc = in_acc && !s_axis_tuser &&
                      int'(s_axis_tdata[11:0]) < MAX_WIDTH &&
                      int'(s_axis_tdata[23:12]) < MAX_HEIGHT;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_region: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= REGION_LAST)
    else $error("bad region code");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    render_acc |=> !s_axis_tready)
    else $error("pixel item accepted while busy");

  a_no_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && !render_acc && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result from an item that gives none");

endmodule

bind multi_stop_gradient_pixel_core msgp_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT)
) u_msgp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
